FILE: rtl/video_bus_memory_map_unit_macros.svh
// Assertion macros for the video bus memory map.
`ifndef VIDEO_BUS_MEMORY_MAP_UNIT_MACROS_SVH
`define VIDEO_BUS_MEMORY_MAP_UNIT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while in reset.
`define VBMM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off while in reset.
`define VBMM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/vbmm_pkg.sv
`default_nettype none

package vbmm_pkg;

    localparam int BUS_W     = 14;
    localparam int NT_IDX_W  = 12;
    localparam int PAL_IDX_W = 5;
    localparam int PAL_W     = 6;
    localparam int PAL_DEPTH = 32;
    localparam int NT_DEPTH  = 4096;

    localparam logic [PAL_W-1:0] PAL_RESET = 6'h3F;

    typedef logic [2:0] t_mirroring;
    localparam t_mirroring MIR_VERTICAL   = 3'd0;
    localparam t_mirroring MIR_HORIZONTAL = 3'd1;
    localparam t_mirroring MIR_SINGLE_LOW = 3'd2;
    localparam t_mirroring MIR_SINGLE_HI  = 3'd3;

    typedef enum logic [1:0] {
        REG_PATTERN,
        REG_NAME,
        REG_PALETTE
    } t_region;

    typedef struct packed {
        logic        mode;
        logic [15:0] address;
        logic [7:0]  write_data;
    } t_in_req;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        pattern_access;
        logic [12:0] pattern_address;
        logic        pattern_write;
        logic [7:0]  pattern_write_data;
    } t_out_req;

    typedef struct packed {
        t_region                region;
        logic [NT_IDX_W-1:0]    nt_idx;
        logic [PAL_IDX_W-1:0]   pal_idx;
    } t_dec;

endpackage

`default_nettype wire

FILE: rtl/vbmm_decode.sv
`default_nettype none

module vbmm_decode
    import vbmm_pkg::*;
(
    input  wire t_mirroring   i_mirroring,
    input  wire logic [15:0]  i_address,
    output t_dec              o_dec
);

    logic [BUS_W-1:0] w_addr;
    logic [1:0]       w_page_in;
    logic [1:0]       w_page;
    logic [4:0]       w_pal;

    assign w_addr    = i_address[BUS_W-1:0];
    assign w_page_in = w_addr[11:10];

    always_comb begin
        unique case (i_mirroring)
            MIR_VERTICAL:   w_page = {1'b0, w_page_in[0]};
            MIR_HORIZONTAL: w_page = {1'b0, w_page_in[1]};
            MIR_SINGLE_LOW: w_page = 2'd0;
            MIR_SINGLE_HI:  w_page = 2'd1;
            default:        w_page = w_page_in;
        endcase
    end

    // palette mirrors of the background entries
    always_comb begin
        w_pal = w_addr[4:0];
        if (w_pal[4] && (w_pal[1:0] == 2'b00)) begin
            w_pal[4] = 1'b0;
        end
    end

    always_comb begin
        if (!w_addr[13]) begin
            o_dec.region = REG_PATTERN;
        end else if (w_addr[13:8] != 6'h3F) begin
            o_dec.region = REG_NAME;
        end else begin
            o_dec.region = REG_PALETTE;
        end
        o_dec.nt_idx  = {w_page, w_addr[9:0]};
        o_dec.pal_idx = w_pal;
    end

endmodule

`default_nettype wire

FILE: rtl/video_bus_memory_map_unit.sv
// Channel   | Dir | Handshake                 | Payload
// ----------+-----+---------------------------+--------------------
// request   | in  | i_in_valid / o_in_stall   | i_in_req  (t_in_req)
// result    | out | o_out_valid / i_out_stall | o_out_rsp (t_out_req)
// config    | in  | i_cfg_we                  | i_cfg_wdata
//
// A request is registered at the RAM read, then at the output register, before
// its result is offered; a new request is taken while an earlier one is in flight.
// Name-table store is one 4096x8 synchronous RAM; palette is a 32x6 RAM
// with per-entry valid bits, so reset clears only those valid bits.
// o_in_stall rises only when both the RAM stage and the output register hold.
`default_nettype none

module video_bus_memory_map_unit
    import vbmm_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [2:0] i_cfg_wdata,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire t_in_req    i_in_req,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output t_out_req        o_out_rsp
);

`include "video_bus_memory_map_unit_macros.svh"

    t_mirroring r_mirroring;
    t_dec       w_dec;
    logic       w_accept;
    logic       w_s1_move;

    logic [7:0]       r_nt_mem [NT_DEPTH];
    logic [PAL_W-1:0] r_pal_mem [PAL_DEPTH];
    logic [PAL_DEPTH-1:0] r_pal_vld;
    logic [7:0]       r_nt_q;
    logic [PAL_W-1:0] r_pal_q;
    logic             r_pal_q_vld;

    logic        r_s1_valid;
    t_region     r_s1_region;
    logic        r_s1_write;
    logic [12:0] r_s1_paddr;
    logic [7:0]  r_s1_wdata;

    logic     r_out_valid;
    t_out_req r_out;
    t_out_req n_out;

    vbmm_decode u_decode (
        .i_mirroring (r_mirroring),
        .i_address   (i_in_req.address),
        .o_dec       (w_dec)
    );

    assign o_in_stall = r_s1_valid && r_out_valid;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_s1_move  = r_s1_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (w_accept && (w_dec.region == REG_NAME)) begin
            if (i_in_req.mode) begin
                r_nt_mem[w_dec.nt_idx] <= i_in_req.write_data;
            end else begin
                r_nt_q <= r_nt_mem[w_dec.nt_idx];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && (w_dec.region == REG_PALETTE)) begin
            if (i_in_req.mode) begin
                r_pal_mem[w_dec.pal_idx] <= i_in_req.write_data[PAL_W-1:0];
            end else begin
                r_pal_q     <= r_pal_mem[w_dec.pal_idx];
                r_pal_q_vld <= r_pal_vld[w_dec.pal_idx];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pal_vld <= '0;
        end else if (w_accept && (w_dec.region == REG_PALETTE) && i_in_req.mode) begin
            r_pal_vld[w_dec.pal_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mirroring <= MIR_VERTICAL;
        end else if (i_cfg_we) begin
            r_mirroring <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_region <= w_dec.region;
            r_s1_write  <= i_in_req.mode;
            r_s1_paddr  <= i_in_req.address[12:0];
            r_s1_wdata  <= i_in_req.write_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_comb begin
        n_out = '0;
        unique case (r_s1_region)
            REG_PATTERN: begin
                n_out.pattern_access  = 1'b1;
                n_out.pattern_address = r_s1_paddr;
                n_out.pattern_write   = r_s1_write;
                if (r_s1_write) begin
                    n_out.pattern_write_data = r_s1_wdata;
                end
            end
            REG_NAME: begin
                if (!r_s1_write) begin
                    n_out.read_data = r_nt_q;
                end
            end
            REG_PALETTE: begin
                if (!r_s1_write) begin
                    n_out.read_data = {2'b00, r_pal_q_vld ? r_pal_q : PAL_RESET};
                end
            end
            default: n_out = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

    `VBMM_ASSERT_NOW(a_pat_write_only_on_pattern,
        o_out_valid && o_out_rsp.pattern_write, o_out_rsp.pattern_access,
        "pattern write flagged outside the pattern region")
    `VBMM_ASSERT_NOW(a_pattern_reads_zero,
        o_out_valid && o_out_rsp.pattern_access, o_out_rsp.read_data == 8'd0,
        "nonzero read data on a pattern access")
    `VBMM_ASSERT_NEXT(a_s1_holds_on_stall,
        r_s1_valid && r_out_valid && i_out_stall,
        r_s1_valid && $stable(r_s1_region) && $stable(r_s1_paddr),
        "RAM stage lost its request while output was stalled")
    `VBMM_ASSERT_NEXT(a_accept_fills_s1,
        w_accept, r_s1_valid,
        "accepted request did not reach the RAM stage")

endmodule

`default_nettype wire

FILE: bench/video_bus_memory_map_unit_tb.sv
`timescale 1ns / 1ps

module video_bus_memory_map_unit_tb;
    import vbmm_pkg::*;

    localparam bit         ACC_READ     = 1'b0;
    localparam bit         ACC_WRITE    = 1'b1;
    localparam t_mirroring MIR_FOUR     = 3'd4;
    localparam t_mirroring MIR_UNUSED5  = 3'd5;
    localparam t_mirroring MIR_UNUSED6  = 3'd6;
    localparam t_mirroring MIR_UNUSED7  = 3'd7;
    localparam int         RAND_PHASES  = 10;
    localparam int         PHASE_ITEMS  = 155;
    localparam int         DRAIN_CYCLES = 6;
    localparam int         WATCHDOG_MAX = 2000;
    localparam int         HOT_DEPTH    = 64;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic [2:0] i_cfg_wdata = '0;
    logic       i_in_valid  = 1'b0;
    t_in_req    i_in_req    = '0;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    t_out_req   o_out_rsp;

    video_bus_memory_map_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_req   (i_in_req),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_rsp  (o_out_rsp)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_in_req    pending_q[$];
    t_out_req   expect_q[$];
    logic [11:0] hot_q[$];
    bit         nt_known[NT_DEPTH];
    logic [7:0] nt_mem[NT_DEPTH];
    logic [5:0] pal_mem[PAL_DEPTH];
    t_mirroring mir_cfg = MIR_VERTICAL;
    int         send_level = 0;
    int         stall_level = 0;
    int         send_gap = 0;
    int         stall_cnt = 0;
    int         err_cnt = 0;
    int         quiet_cnt = 0;
    bit         req_taken = 1'b0;
    bit         res_taken = 1'b0;

    function automatic int draw_wait(int level);
        return ($urandom_range(0, 3) < level) ? $urandom_range(0, 16) : 0;
    endfunction

    function automatic t_region region_of(logic [15:0] a);
        if (a[13:0] <= 14'h1FFF) return REG_PATTERN;
        if (a[13:0] <= 14'h3EFF) return REG_NAME;
        return REG_PALETTE;
    endfunction

    function automatic logic [11:0] nt_slot(logic [15:0] a, t_mirroring m);
        logic [1:0] pg;
        pg = a[11:10];
        case (m)
            MIR_VERTICAL:   pg = {1'b0, pg[0]};
            MIR_HORIZONTAL: pg = {1'b0, pg[1]};
            MIR_SINGLE_LOW: pg = 2'd0;
            MIR_SINGLE_HI:  pg = 2'd1;
            default: ;
        endcase
        return {pg, a[9:0]};
    endfunction

    function automatic logic [4:0] pal_slot(logic [15:0] a);
        logic [4:0] p;
        p = a[4:0];
        if (p[4] && p[1:0] == 2'b00) p[4] = 1'b0;
        return p;
    endfunction

    function automatic t_out_req map_access(t_in_req r);
        t_out_req o;
        logic [11:0] ni;
        logic [4:0]  pi;
        o = '0;
        case (region_of(r.address))
            REG_PATTERN: begin
                o.pattern_access  = 1'b1;
                o.pattern_address = r.address[12:0];
                if (r.mode == ACC_WRITE) begin
                    o.pattern_write      = 1'b1;
                    o.pattern_write_data = r.write_data;
                end
            end
            REG_NAME: begin
                ni = nt_slot(r.address, mir_cfg);
                if (r.mode == ACC_WRITE) nt_mem[ni] = r.write_data;
                else o.read_data = nt_mem[ni];
            end
            default: begin
                pi = pal_slot(r.address);
                if (r.mode == ACC_WRITE) pal_mem[pi] = r.write_data[5:0];
                else o.read_data = {2'b00, pal_mem[pi]};
            end
        endcase
        return o;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        err_cnt++;
    endtask

    // reads of never-written name-table bytes are turned into writes
    task automatic queue_access(bit md, logic [15:0] a, logic [7:0] wd);
        t_in_req r;
        logic [11:0] ni;
        if (region_of(a) == REG_NAME) begin
            ni = nt_slot(a, mir_cfg);
            if (!nt_known[ni]) md = ACC_WRITE;
            if (md == ACC_WRITE) begin
                nt_known[ni] = 1'b1;
                hot_q.push_back(a[11:0]);
                if (hot_q.size() > HOT_DEPTH) void'(hot_q.pop_front());
            end
        end
        r.mode       = md;
        r.address    = a;
        r.write_data = wd;
        pending_q.push_back(r);
    endtask

    task automatic queue_random();
        int pick;
        bit md;
        logic [15:0] a;
        pick = $urandom_range(0, 9);
        md   = 1'($urandom_range(0, 1));
        a    = 16'($urandom);
        if (pick < 3) begin
            a[13] = 1'b0;
        end else if (pick < 7) begin
            if (hot_q.size() != 0 && $urandom_range(0, 1)) begin
                a[11:0]  = hot_q[$urandom_range(0, hot_q.size() - 1)];
                a[11:10] = 2'($urandom);
                md       = ($urandom_range(0, 3) != 0) ? ACC_READ : ACC_WRITE;
            end
            a[13:12] = 2'($urandom_range(2, 3));
            if (a[13:8] == 6'h3F) a[8] = 1'b0;
        end else begin
            a[13:8] = 6'h3F;
        end
        queue_access(md, a, 8'($urandom));
    endtask

    task automatic drain();
        while (pending_q.size() != 0 || i_in_valid || expect_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mirroring(t_mirroring m);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        mir_cfg = m;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !req_taken) begin
        end else if (send_gap != 0) begin
            send_gap   <= send_gap - 1;
            i_in_valid <= 1'b0;
        end else if (pending_q.size() != 0) begin
            i_in_req   <= pending_q.pop_front();
            i_in_valid <= 1'b1;
            send_gap   <= draw_wait(send_level);
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // result stall driver
    always @(negedge i_clk) begin : stall_drv
        int n;
        if (!i_rst_n) begin
            n = 0;
        end else if (res_taken) begin
            n = draw_wait(stall_level);
        end else begin
            n = (stall_cnt > 0) ? stall_cnt - 1 : 0;
        end
        stall_cnt   <= n;
        i_out_stall <= (n != 0);
    end

    // monitor and checker
    always @(posedge i_clk) begin : monitor
        t_out_req want;
        bit in_acc;
        bit out_acc;
        in_acc  = i_rst_n && i_in_valid && (o_in_stall === 1'b0);
        out_acc = i_rst_n && (o_out_valid === 1'b1) && !i_out_stall;
        req_taken <= in_acc;
        res_taken <= out_acc;
        if (out_acc) begin
            if (expect_q.size() == 0) begin
                report_mismatch("unexpected result", int'(o_out_rsp), 0);
            end else begin
                want = expect_q.pop_front();
                if (o_out_rsp.read_data !== want.read_data)
                    report_mismatch("read_data", int'(o_out_rsp.read_data),
                                    int'(want.read_data));
                if (o_out_rsp.pattern_access !== want.pattern_access)
                    report_mismatch("pattern_access", int'(o_out_rsp.pattern_access),
                                    int'(want.pattern_access));
                if (o_out_rsp.pattern_address !== want.pattern_address)
                    report_mismatch("pattern_address", int'(o_out_rsp.pattern_address),
                                    int'(want.pattern_address));
                if (o_out_rsp.pattern_write !== want.pattern_write)
                    report_mismatch("pattern_write", int'(o_out_rsp.pattern_write),
                                    int'(want.pattern_write));
                if (o_out_rsp.pattern_write_data !== want.pattern_write_data)
                    report_mismatch("pattern_write_data",
                                    int'(o_out_rsp.pattern_write_data),
                                    int'(want.pattern_write_data));
            end
        end
        if (in_acc) expect_q.push_back(map_access(i_in_req));
        if (!i_rst_n || in_acc || out_acc) begin
            quiet_cnt <= 0;
        end else if (quiet_cnt + 1 >= WATCHDOG_MAX) begin
            $display("video_bus_memory_map_unit_tb NOT OK");
            $finish;
        end else begin
            quiet_cnt <= quiet_cnt + 1;
        end
    end

    initial begin : stim
        t_mirroring mir_plan[RAND_PHASES];
        mir_plan = '{MIR_HORIZONTAL, MIR_SINGLE_LOW, MIR_SINGLE_HI, MIR_FOUR,
                     MIR_UNUSED5, MIR_UNUSED6, MIR_UNUSED7, MIR_VERTICAL,
                     MIR_FOUR, MIR_SINGLE_HI};
        foreach (pal_mem[i]) pal_mem[i] = PAL_RESET;
        foreach (nt_mem[i]) nt_mem[i] = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset mirroring (vertical)
        queue_access(ACC_READ,  16'h0000, 8'h00);
        queue_access(ACC_WRITE, 16'h1FFF, 8'hFF);
        queue_access(ACC_WRITE, 16'h1000, 8'h00);
        queue_access(ACC_READ,  16'hDFFF, 8'hFF);
        queue_access(ACC_READ,  16'hC000, 8'h00);
        queue_access(ACC_READ,  16'h3F00, 8'h00);
        queue_access(ACC_READ,  16'hFFFF, 8'h00);
        queue_access(ACC_WRITE, 16'h3F10, 8'hFF);
        queue_access(ACC_READ,  16'h3F00, 8'h00);
        queue_access(ACC_WRITE, 16'h3F1C, 8'hAA);
        queue_access(ACC_READ,  16'h3F0C, 8'h00);
        queue_access(ACC_READ,  16'h3F11, 8'h00);
        queue_access(ACC_WRITE, 16'h3F1F, 8'h40);
        queue_access(ACC_READ,  16'h7F1F, 8'h00);
        queue_access(ACC_WRITE, 16'h2000, 8'h00);
        queue_access(ACC_WRITE, 16'h3EFF, 8'hFF);
        queue_access(ACC_WRITE, 16'h2400, 8'h5A);
        queue_access(ACC_READ,  16'h2800, 8'h00);
        queue_access(ACC_READ,  16'h2C00, 8'h00);
        queue_access(ACC_READ,  16'hBEFF, 8'h00);
        queue_access(ACC_READ,  16'h3AFF, 8'h00);
        queue_access(ACC_WRITE, 16'hE123, 8'hC3);
        drain();

        for (int p = 0; p < RAND_PHASES; p++) begin
            write_mirroring(mir_plan[p]);
            send_level  = (p == 0) ? 0 : $urandom_range(0, 4);
            stall_level = (p == 0) ? 0 : $urandom_range(0, 4);
            repeat (PHASE_ITEMS) queue_random();
            drain();
        end

        if (err_cnt == 0 && expect_q.size() == 0) begin
            $display("video_bus_memory_map_unit_tb OK");
        end else begin
            $display("video_bus_memory_map_unit_tb NOT OK");
        end
        $finish;
    end

endmodule
